// ===== rtl/tlrq_pkg.sv =====
package tlrq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_ID_WIDTH    = 8;

    localparam int OP_W       = 3;
    localparam int PRIO_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int NUM_LEVELS = 3;
    localparam int LIDX_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ      = 3'd0,
        OP_DEQ_HI   = 3'd1,
        OP_DEQ_LVL  = 3'd2,
        OP_PEEK_HI  = 3'd3,
        OP_PEEK_LVL = 3'd4
    } op_t;

    localparam logic [PRIO_W-1:0] PRIO_IDLE = 2'd0;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_OP = 2'd2;

    typedef enum logic [1:0] {
        K_PUSH     = 2'd0,
        K_IDLE_SET = 2'd1,
        K_FETCH    = 2'd2,
        K_BAD      = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               highest;
        logic               take;
        logic [PRIO_W-1:0]  level;
    } cmd_t;

endpackage

// ===== rtl/tlrq_in_if.sv =====
interface tlrq_in_if #(
    parameter int ID_WIDTH = tlrq_pkg::DEF_ID_WIDTH
);
    import tlrq_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [ID_WIDTH-1:0] thread_id;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, output op, output thread_id, output priority_req,
                    input ready);
    modport sink   (input valid, input op, input thread_id, input priority_req,
                    output ready);
endinterface

// ===== rtl/tlrq_out_if.sv =====
interface tlrq_out_if #(
    parameter int ID_WIDTH = tlrq_pkg::DEF_ID_WIDTH
);
    import tlrq_pkg::*;

    logic                valid;
    logic                ready;
    logic [ID_WIDTH-1:0] thread_out;
    logic                found;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output thread_out, output found, output status,
                    input ready);
    modport sink   (input valid, input thread_out, input found, input status,
                    output ready);
endinterface

// ===== rtl/tlrq_cmd_fifo.sv =====
module tlrq_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             avail,
    output logic [WIDTH-1:0] pop_data
);
    // two-entry queue
    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign avail    = (cnt_reg != 2'd0);
    assign pop_data = data_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== rtl/tlrq_front.sv =====
module tlrq_front #(
    parameter int ID_WIDTH = tlrq_pkg::DEF_ID_WIDTH
) (
    tlrq_in_if.sink              in_ch,
    output logic                 push,
    output tlrq_pkg::cmd_t       push_cmd,
    output logic [ID_WIDTH-1:0]  push_id,
    input  logic                 full
);
    import tlrq_pkg::*;

    assign in_ch.ready = !full;
    assign push        = in_ch.valid;
    assign push_id     = in_ch.thread_id;

    // classify op into a back-end command
    always_comb
    begin
        push_cmd.kind    = K_BAD;
        push_cmd.highest = 1'b0;
        push_cmd.take    = 1'b0;
        push_cmd.level   = in_ch.priority_req;
        case (op_t'(in_ch.op))
            OP_ENQ:
            begin
                push_cmd.kind = (in_ch.priority_req == PRIO_IDLE) ? K_IDLE_SET : K_PUSH;
            end
            OP_DEQ_HI:
            begin
                push_cmd.kind    = K_FETCH;
                push_cmd.highest = 1'b1;
                push_cmd.take    = 1'b1;
            end
            OP_DEQ_LVL:
            begin
                push_cmd.kind = K_FETCH;
                push_cmd.take = 1'b1;
            end
            OP_PEEK_HI:
            begin
                push_cmd.kind    = K_FETCH;
                push_cmd.highest = 1'b1;
            end
            OP_PEEK_LVL:
            begin
                push_cmd.kind = K_FETCH;
            end
            default:
            begin
                push_cmd.kind = K_BAD;
            end
        endcase
    end
endmodule

// ===== rtl/tlrq_back.sv =====
module tlrq_back #(
    parameter int QUEUE_DEPTH = tlrq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = tlrq_pkg::DEF_ID_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_avail,
    input  tlrq_pkg::cmd_t       cmd,
    input  logic [ID_WIDTH-1:0]  cmd_id,
    output logic                 cmd_pop,
    tlrq_out_if.source           out_ch
);
    import tlrq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = PW + 1;

    typedef enum logic [1:0] {
        ST_ISSUE  = 2'b01,
        ST_RESULT = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [PW-1:0]        head_reg [NUM_LEVELS];
    logic [PW-1:0]        head_next [NUM_LEVELS];
    logic [CW-1:0]        cnt_reg [NUM_LEVELS];
    logic [CW-1:0]        cnt_next [NUM_LEVELS];
    logic [ID_WIDTH-1:0]  idle_id_reg, idle_id_next;
    logic                 idle_valid_reg, idle_valid_next;

    logic                 pend_found_reg, pend_found_next;
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic                 pend_fifo_reg, pend_fifo_next;
    logic [LIDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [ID_WIDTH-1:0]  pend_idle_reg, pend_idle_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ID_WIDTH-1:0]  out_id_reg, out_id_next;
    logic                 out_found_reg, out_found_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    logic [ID_WIDTH-1:0]  rd_data_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] wr_en, rd_en;
    logic [PW-1:0]        wr_ptr;

    logic [NUM_LEVELS-1:0] nonempty;
    logic                 sel_fifo;
    logic [LIDX_W-1:0]    sel_idx;
    logic [PW-1:0]        sel_head;
    logic [CW-1:0]        sel_cnt;
    logic [SW-1:0]        tail_sum;
    logic                 sel_full;
    logic [PW-1:0]        head_inc;
    logic                 issue;
    logic                 out_free;

    assign issue    = (state_reg == ST_ISSUE) && cmd_avail;
    assign cmd_pop  = issue;
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            nonempty[i] = (cnt_reg[i] != '0);
        end
    end

    // level selection: highest nonempty level (else the idle slot), or the named level
    always_comb
    begin
        sel_fifo = 1'b1;
        sel_idx  = LIDX_W'(0);
        if (cmd.highest)
        begin
            if (nonempty[2])
            begin
                sel_idx = LIDX_W'(2);
            end
            else if (nonempty[1])
            begin
                sel_idx = LIDX_W'(1);
            end
            else if (nonempty[0])
            begin
                sel_idx = LIDX_W'(0);
            end
            else
            begin
                sel_fifo = 1'b0;
            end
        end
        else if (cmd.level == PRIO_IDLE)
        begin
            sel_fifo = 1'b0;
        end
        else
        begin
            sel_idx = LIDX_W'(cmd.level - 2'd1);
        end
    end

    assign sel_head = head_reg[sel_idx];
    assign sel_cnt  = cnt_reg[sel_idx];
    assign sel_full = (sel_cnt == CW'(QUEUE_DEPTH));
    assign head_inc = (sel_head == PW'(QUEUE_DEPTH - 1)) ? '0 : sel_head + PW'(1);

    always_comb
    begin
        tail_sum = {1'b0, sel_head} + SW'(sel_cnt);
        if (tail_sum >= SW'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SW'(QUEUE_DEPTH);
        end
    end

    assign wr_ptr = tail_sum[PW-1:0];

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        cnt_next         = cnt_reg;
        idle_id_next     = idle_id_reg;
        idle_valid_next  = idle_valid_reg;
        pend_found_next  = pend_found_reg;
        pend_status_next = pend_status_reg;
        pend_fifo_next   = pend_fifo_reg;
        pend_idx_next    = pend_idx_reg;
        pend_idle_next   = pend_idle_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_id_next      = out_id_reg;
        out_found_next   = out_found_reg;
        out_status_next  = out_status_reg;
        wr_en            = '0;
        rd_en            = '0;

        case (state_reg)
            ST_ISSUE:
            begin
                if (issue)
                begin
                    state_next       = ST_RESULT;
                    pend_found_next  = 1'b0;
                    pend_status_next = STATUS_OK;
                    pend_fifo_next   = sel_fifo;
                    pend_idx_next    = sel_idx;
                    pend_idle_next   = idle_id_reg;
                    case (cmd.kind)
                        K_PUSH:
                        begin
                            if (sel_full)
                            begin
                                pend_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en[sel_idx]    = 1'b1;
                                cnt_next[sel_idx] = sel_cnt + CW'(1);
                            end
                        end
                        K_IDLE_SET:
                        begin
                            idle_id_next    = cmd_id;
                            idle_valid_next = 1'b1;
                        end
                        K_FETCH:
                        begin
                            if (sel_fifo)
                            begin
                                pend_found_next = nonempty[sel_idx];
                                if (nonempty[sel_idx])
                                begin
                                    rd_en[sel_idx] = 1'b1;
                                    if (cmd.take)
                                    begin
                                        head_next[sel_idx] = head_inc;
                                        cnt_next[sel_idx]  = sel_cnt - CW'(1);
                                    end
                                end
                            end
                            else
                            begin
                                pend_found_next = idle_valid_reg;
                                if (cmd.take)
                                begin
                                    idle_valid_next = 1'b0;
                                    idle_id_next    = '0;
                                end
                            end
                        end
                        default:
                        begin
                            pend_status_next = STATUS_BAD_OP;
                        end
                    endcase
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next      = ST_ISSUE;
                    out_valid_next  = 1'b1;
                    out_found_next  = pend_found_reg;
                    out_status_next = pend_status_reg;
                    if (!pend_found_reg)
                    begin
                        out_id_next = '0;
                    end
                    else if (pend_fifo_reg)
                    begin
                        out_id_next = rd_data_reg[pend_idx_reg];
                    end
                    else
                    begin
                        out_id_next = pend_idle_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_ISSUE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ISSUE;
            head_reg       <= '{default: '0};
            cnt_reg        <= '{default: '0};
            idle_id_reg    <= '0;
            idle_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            cnt_reg        <= cnt_next;
            idle_id_reg    <= idle_id_next;
            idle_valid_reg <= idle_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_found_reg  <= pend_found_next;
        pend_status_reg <= pend_status_next;
        pend_fifo_reg   <= pend_fifo_next;
        pend_idx_reg    <= pend_idx_next;
        pend_idle_reg   <= pend_idle_next;
        out_id_reg      <= out_id_next;
        out_found_reg   <= out_found_next;
        out_status_reg  <= out_status_next;
    end

    // one ring buffer per level, registered read
    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_lvl
        logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en[g])
            begin
                mem[wr_ptr] <= cmd_id;
            end
            if (rd_en[g])
            begin
                rd_data_reg[g] <= mem[sel_head];
            end
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.thread_out = out_id_reg;
    assign out_ch.found      = out_found_reg;
    assign out_ch.status     = out_status_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CW'(QUEUE_DEPTH) && cnt_reg[1] <= CW'(QUEUE_DEPTH)
        && cnt_reg[2] <= CW'(QUEUE_DEPTH))
        else $error("level count beyond depth");

    a_pop_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> state_reg == ST_RESULT)
        else $error("issued command did not move to result");

    a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result loaded outside result state");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_found_reg |-> out_status_reg == STATUS_OK)
        else $error("found item with error status");
endmodule

// ===== rtl/three_level_ready_queue_unit.sv =====
// Three-level ready queue: a thread scheduler with low, normal and high FIFOs of
// QUEUE_DEPTH entries each plus a single idle slot. Each input item is one
// operation (enqueue, dequeue highest, dequeue level, peek highest, peek level)
// and yields exactly one result item carrying thread_out, found and status.
// The front end classifies operations and drops them into a two-entry command
// queue; the back end executes them one at a time against the head/count
// registers and the per-level buffer RAMs. An operation passes through the
// issue state and then the result state, which loads the output register
// from the registered RAM read once the output is free; the back end takes
// no new item until that result is loaded, so a stalled output holds it.
// Queue storage is not cleared at reset: head and count only ever expose
// written entries, so no clearing pass is needed.
module three_level_ready_queue_unit #(
    parameter int QUEUE_DEPTH = tlrq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = tlrq_pkg::DEF_ID_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    tlrq_in_if.sink     in_ch,
    tlrq_out_if.source  out_ch
);
    import tlrq_pkg::*;

    localparam int CMD_W = $bits(cmd_t) + ID_WIDTH;

    // front to queue
    logic                push;
    cmd_t                push_cmd;
    logic [ID_WIDTH-1:0] push_id;
    logic                q_full;

    // queue to back
    logic                q_avail;
    logic                q_pop;
    logic [CMD_W-1:0]    q_data;
    cmd_t                back_cmd;
    logic [ID_WIDTH-1:0] back_id;

    tlrq_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .in_ch    (in_ch),
        .push     (push),
        .push_cmd (push_cmd),
        .push_id  (push_id),
        .full     (q_full)
    );

    tlrq_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cmd, push_id}),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_data)
    );

    assign back_cmd = cmd_t'(q_data[CMD_W-1:ID_WIDTH]);
    assign back_id  = q_data[ID_WIDTH-1:0];

    tlrq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (q_avail),
        .cmd       (back_cmd),
        .cmd_id    (back_id),
        .cmd_pop   (q_pop),
        .out_ch    (out_ch)
    );
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tlrq_pkg::*;

    localparam int DEPTH  = DEF_QUEUE_DEPTH;
    localparam int ID_W   = DEF_ID_WIDTH;
    localparam int HALF_P = 4;

    // Levels beyond the idle slot; the idle level comes from the package
    localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd1;
    localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd2;
    localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd3;

    // Op codes the block does not know
    localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;

    typedef struct packed {
        logic [ID_W-1:0]     thread_out;
        logic                found;
        logic [STATUS_W-1:0] status;
    } sched_result_t;

    // Shadow of the scheduler state, plus the results it still owes
    class ready_queue_shadow;
        logic [ID_W-1:0] level_fifo [PRIO_LOW:PRIO_HIGH][$];
        logic [ID_W-1:0] idle_id;
        logic            idle_valid;
        sched_result_t   owed_results[$];
        int unsigned     errors;

        function new();
            idle_id    = '0;
            idle_valid = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned level_count(logic [PRIO_W-1:0] lvl);
            if (lvl == PRIO_IDLE)
                return 32'(idle_valid);
            return level_fifo[lvl].size();
        endfunction

        function logic [PRIO_W-1:0] highest_level();
            if (level_fifo[PRIO_HIGH].size() != 0)
                return PRIO_HIGH;
            if (level_fifo[PRIO_NORMAL].size() != 0)
                return PRIO_NORMAL;
            if (level_fifo[PRIO_LOW].size() != 0)
                return PRIO_LOW;
            return PRIO_IDLE;
        endfunction

        function void fetch(logic [PRIO_W-1:0] lvl, logic take, inout sched_result_t r);
            if (lvl == PRIO_IDLE)
            begin
                if (idle_valid)
                begin
                    r.found      = 1'b1;
                    r.thread_out = idle_id;
                    if (take)
                    begin
                        idle_valid = 1'b0;
                        idle_id    = '0;
                    end
                end
            end
            else if (level_fifo[lvl].size() != 0)
            begin
                r.found      = 1'b1;
                r.thread_out = level_fifo[lvl][0];
                if (take)
                    level_fifo[lvl].delete(0);
            end
        endfunction

        function void note_op(logic [OP_W-1:0] op, logic [ID_W-1:0] tid,
                              logic [PRIO_W-1:0] prio);
            sched_result_t r;
            logic          take;
            r    = '0;
            take = (op == OP_DEQ_HI) || (op == OP_DEQ_LVL);
            case (op)
                OP_ENQ:
                begin
                    if (prio == PRIO_IDLE)
                    begin
                        idle_id    = tid;
                        idle_valid = 1'b1;
                    end
                    else if (level_fifo[prio].size() >= DEPTH)
                        r.status = STATUS_FULL;
                    else
                        level_fifo[prio].insert(level_fifo[prio].size(), tid);
                end
                OP_DEQ_HI, OP_PEEK_HI:   fetch(highest_level(), take, r);
                OP_DEQ_LVL, OP_PEEK_LVL: fetch(prio, take, r);
                default:                 r.status = STATUS_BAD_OP;
            endcase
            owed_results.insert(owed_results.size(), r);
        endfunction

        task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
            $display("%0t ns  mismatch on %s: got %0h, want %0h", $time, what, got_v, want_v);
            errors++;
        endtask

        task check_result(sched_result_t got);
            sched_result_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch("unowed result", 32'(got), 0);
                return;
            end
            want = owed_results[0];
            owed_results.delete(0);
            if (got.thread_out !== want.thread_out)
                report_mismatch("thread_out", 32'(got.thread_out), 32'(want.thread_out));
            if (got.found !== want.found)
                report_mismatch("found", 32'(got.found), 32'(want.found));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;

    tlrq_in_if  #(.ID_WIDTH(ID_W)) in_ch ();
    tlrq_out_if #(.ID_WIDTH(ID_W)) out_ch ();

    three_level_ready_queue_unit #(
        .QUEUE_DEPTH (DEPTH),
        .ID_WIDTH    (ID_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    ready_queue_shadow shadow;
    bit                bursts_on;   // random idle bursts on both channels
    int unsigned       ops_sent;

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_P) clk = ~clk;

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #(2_000_000);
        $display("status: fail");
        $finish;
    end

    // Result side: ready drops for random stretches while bursts are on
    initial
    begin
        int unsigned stall;
        stall        = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (bursts_on && $urandom_range(0, 9) == 0)
                    stall = $urandom_range(1, 13);
            end
        end
    end

    // Every accepted result is checked against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            shadow.check_result('{thread_out: out_ch.thread_out,
                                  found:      out_ch.found,
                                  status:     out_ch.status});
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    // valid stays high between back-to-back items and only drops for a gap.
    task automatic issue_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] tid,
                            input logic [PRIO_W-1:0] prio);
        if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.thread_id    <= tid;
        in_ch.priority_req <= prio;
        do
            @(posedge clk);
        while (!in_ch.ready);
        shadow.note_op(op, tid, prio);
        ops_sent++;
        @(negedge clk);
    endtask

    // Sender holds off until every owed result has come back
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (shadow.owed_results.size() != 0);
    endtask

    task automatic random_op();
        int unsigned     pick;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_ENQ;
        else if (pick < 55)
            op = OP_DEQ_HI;
        else if (pick < 70)
            op = OP_DEQ_LVL;
        else if (pick < 80)
            op = OP_PEEK_HI;
        else if (pick < 93)
            op = OP_PEEK_LVL;
        else
            op = OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        issue_op(op, ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 3)));
    endtask

    // Push one level until it overflows, then drain it past empty; the
    // heads end up at new offsets, so later fills exercise the wrap
    task automatic fill_and_drain();
        logic [PRIO_W-1:0] lvl;
        int unsigned       pick;
        lvl = PRIO_W'($urandom_range(PRIO_LOW, PRIO_HIGH));
        while (shadow.level_count(lvl) < DEPTH)
        begin
            if ($urandom_range(0, 9) == 0)
                issue_op(OP_PEEK_LVL, ID_W'($urandom_range(0, 255)), lvl);
            else
                issue_op(OP_ENQ, ID_W'($urandom_range(0, 255)), lvl);
        end
        repeat ($urandom_range(1, 3))
            issue_op(OP_ENQ, ID_W'($urandom_range(0, 255)), lvl);
        while (shadow.level_count(lvl) != 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                issue_op(OP_DEQ_LVL, ID_W'($urandom_range(0, 255)), lvl);
            else if (pick < 8)
                issue_op(OP_PEEK_LVL, ID_W'($urandom_range(0, 255)), lvl);
            else if (pick < 9)
                issue_op(OP_PEEK_HI, ID_W'($urandom_range(0, 255)),
                         PRIO_W'($urandom_range(0, 3)));
            else
                issue_op(OP_ENQ, ID_W'($urandom_range(0, 255)), lvl);
        end
        issue_op(OP_DEQ_LVL, ID_W'($urandom_range(0, 255)), lvl);
    endtask

    initial
    begin
        int unsigned tail;
        bit          held;
        shadow             = new();
        bursts_on          = 1'b1;
        ops_sent           = 0;
        held               = 1'b0;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_ENQ;
        in_ch.thread_id    = '0;
        in_ch.priority_req = PRIO_IDLE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: everything empty, no idle thread
        issue_op(OP_PEEK_HI, 8'h00, PRIO_IDLE);
        issue_op(OP_DEQ_HI, 8'hFF, PRIO_HIGH);
        issue_op(OP_PEEK_LVL, 8'h00, PRIO_IDLE);
        issue_op(OP_PEEK_LVL, 8'h00, PRIO_LOW);
        issue_op(OP_PEEK_LVL, 8'h00, PRIO_HIGH);
        issue_op(OP_DEQ_LVL, 8'h00, PRIO_NORMAL);
        issue_op(OP_DEQ_LVL, 8'h00, PRIO_IDLE);
        // Idle slot: set, overwrite, then taken by dequeue-highest and cleared
        issue_op(OP_ENQ, 8'h00, PRIO_IDLE);
        issue_op(OP_PEEK_HI, 8'h00, PRIO_IDLE);
        issue_op(OP_ENQ, 8'hFF, PRIO_IDLE);
        issue_op(OP_PEEK_LVL, 8'h00, PRIO_IDLE);
        issue_op(OP_DEQ_HI, 8'h00, PRIO_IDLE);
        issue_op(OP_DEQ_LVL, 8'h00, PRIO_IDLE);
        // Level order, with an idle thread that must not win over a queue
        issue_op(OP_ENQ, 8'h5A, PRIO_IDLE);
        issue_op(OP_ENQ, 8'h01, PRIO_LOW);
        issue_op(OP_ENQ, 8'h80, PRIO_NORMAL);
        issue_op(OP_ENQ, 8'hFF, PRIO_HIGH);
        issue_op(OP_ENQ, 8'h00, PRIO_HIGH);
        issue_op(OP_PEEK_HI, 8'h00, PRIO_IDLE);
        issue_op(OP_DEQ_HI, 8'h00, PRIO_IDLE);
        issue_op(OP_DEQ_LVL, 8'h00, PRIO_LOW);
        issue_op(OP_DEQ_HI, 8'h00, PRIO_IDLE);
        // Unknown ops
        issue_op(OP_BAD_FIRST, 8'hFF, PRIO_HIGH);
        issue_op(OP_BAD_MID, 8'h00, PRIO_LOW);
        issue_op(OP_BAD_LAST, 8'hAA, PRIO_IDLE);

        // Random part: a full overflow first, then mixed bursts
        fill_and_drain();
        while (ops_sent < 480)
        begin
            if (!held && ops_sent > 280)
            begin
                hold_until_drained();
                held = 1'b1;
            end
            if (ops_sent > 420)
                bursts_on = 1'b0;
            if (ops_sent < 380 && $urandom_range(0, 11) == 0)
                fill_and_drain();
            else
                repeat ($urandom_range(10, 30))
                    random_op();
        end

        in_ch.valid <= 1'b0;
        tail = 0;
        while (shadow.owed_results.size() != 0 && tail < 20000)
        begin
            @(posedge clk);
            tail++;
        end
        repeat (16) @(posedge clk);
        if (shadow.owed_results.size() != 0)
            shadow.report_mismatch("results never returned", shadow.owed_results.size(), 0);

        if (shadow.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tlrq_pkg.sv
rtl/tlrq_in_if.sv
rtl/tlrq_out_if.sv
rtl/tlrq_cmd_fifo.sv
rtl/tlrq_front.sv
rtl/tlrq_back.sv
rtl/three_level_ready_queue_unit.sv
bench/tb.sv
